// ===== sv/ewah_pkg.sv =====
// Shared types, constants and helper functions of the EWAH bitmap encoder.
// Depends on nothing; the interface file and the top level refer to it by scoped names.
package ewah_pkg;

	localparam int WORD_BITS    = 64;
	localparam int INDEX_BITS   = 20;
	localparam int COUNT_BITS   = 21;
	localparam int TOTAL_BITS_W = 48;
	localparam int QDEPTH       = 16;
	localparam int QPTR_BITS    = 4;
	localparam logic [3:0] MAX_RESULTS = 4'd8;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_RUN_START,
		S_RUN_BODY,
		S_RUN_MARK,
		S_CHK_START,
		S_CHK_BODY,
		S_CHK_REST,
		S_INTEG,
		S_INT_PUSH,
		S_FINISH
	} seq_state_t;

	// One word-memory write as held in the result queue.
	typedef struct packed {
		logic [INDEX_BITS-1:0] word_index;
		logic [WORD_BITS-1:0]  word_value;
		logic [COUNT_BITS-1:0] word_count;
	} entry_t;

	// Mask of the k low bits, k from 0 to 64.
	function automatic logic [WORD_BITS-1:0] low_mask(input logic [6:0] k);
		logic [WORD_BITS-1:0] m;
		if (k[6]) begin
			m = '1;
		end else begin
			m = (64'd1 << k[5:0]) - 64'd1;
		end
		return m;
	endfunction

	// Saturating add to the bit total.
	function automatic logic [TOTAL_BITS_W-1:0] sat_add(input logic [TOTAL_BITS_W-1:0] a,
			input logic [31:0] k);
		logic [TOTAL_BITS_W:0] s;
		s = {1'b0, a} + {17'd0, k};
		return s[TOTAL_BITS_W] ? '1 : s[TOTAL_BITS_W-1:0];
	endfunction

endpackage

// ===== sv/ewah_item_if.sv =====
// Input and result channel interfaces of the EWAH bitmap encoder.
// Depends on ewah_pkg for the field widths.
interface ewah_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [63:0] chunk_value;
	logic [6:0]  chunk_bits;
	logic        run_bit;
	logic [31:0] run_length;

	modport source(output valid, operation, chunk_value, chunk_bits, run_bit, run_length,
		input ready);
	modport sink(input valid, operation, chunk_value, chunk_bits, run_bit, run_length,
		output ready);
endinterface

interface ewah_result_if;
	logic                                 valid;
	logic                                 ready;
	logic [ewah_pkg::INDEX_BITS-1:0]      word_index;
	logic [ewah_pkg::WORD_BITS-1:0]       word_value;
	logic [ewah_pkg::COUNT_BITS-1:0]      word_count;
	logic [ewah_pkg::TOTAL_BITS_W-1:0]    total_bits;
	logic                                 overflow;
	logic                                 last_write;

	modport source(output valid, word_index, word_value, word_count, total_bits, overflow,
		last_write, input ready);
	modport sink(input valid, word_index, word_value, word_count, total_bits, overflow,
		last_write, output ready);
endinterface

// ===== sv/ewah_bitmap_encoder_unit.sv =====
// Top level of the EWAH bitmap encoder: input holding register, write sequencer,
// result queue memory and output register. Depends on ewah_pkg and the channel interfaces.
//
// The encoder appends literal chunks and runs to an EWAH bitmap kept in an external word
// memory and reports each word write as one result beat (index, value, word count after the
// write, bit total, sticky overflow, last-write flag). An item is taken into a holding
// register and then passes through the sequencer: a step to take it, one step per word
// write, a closing step, and the steps that write nothing: in a non-empty bitmap, the start
// step of a chunk, or of a run that begins on a word boundary, and the marker step of a long
// run that leaves the marker as it is. At the default widths an item makes one to six writes;
// each step makes at most one, as the result queue has a single write port.
// Results drain from the 16-entry queue at one beat per cycle while the receiver is ready,
// while the next item is already being worked on; an item starts only when 8 queue entries
// are free. An item that would overflow the word memory or need more than 8 writes leaves
// the state unchanged and yields one beat that rewrites the last word with overflow set.
// Empty items give no beat and are consumed in the idle state.
module ewah_bitmap_encoder_unit #(
	parameter int CLEAN_COUNT_BITS = 32,
	parameter int DIRTY_COUNT_BITS = 31,
	parameter int MAX_WORDS        = 1048576
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ewah_item_if.sink            item,
	ewah_result_if.source        result
);

	localparam logic [32:0] CMAX_X     = (33'd1 << CLEAN_COUNT_BITS) - 33'd1;
	localparam logic [31:0] CMAX       = CMAX_X[31:0];
	localparam logic [63:0] CLEAN_MASK = {32'd0, CMAX} << DIRTY_COUNT_BITS;
	localparam logic [63:0] DMAX64     = (64'd1 << DIRTY_COUNT_BITS) - 64'd1;
	localparam logic [20:0] MAXW       = 21'(MAX_WORDS);

	// Holding register for one input beat.
	logic        hv_q, h_op_q, h_bit_q;
	logic [63:0] h_v_q;
	logic [6:0]  h_b_q;
	logic [31:0] h_n_q;
	logic        h_zero, take, start, space;

	// Sequencer and working state.
	ewah_pkg::seq_state_t state_q, state_d, ret_q, ret_d;
	logic [47:0] bt_q, bt_d, cbt_q;
	logic [20:0] wt_q, wt_d, cwt_q;
	logic [19:0] mp_q, mp_d, cmp_q;
	logic [63:0] mc_q, mc_d, cmc_q;
	logic [63:0] tail_q, tail_d, ctail_q;
	logic [5:0]  ph_q, ph_d, cph_q;
	logic        ovf_q, fail_q, fail_set;
	logic [3:0]  ecnt_q;

	// Current item.
	logic        bit_q;
	logic [31:0] n_q, n_d, cb_q, cb_d;
	logic [63:0] v_q;
	logic [6:0]  b_q, sh_q, sh_d, rem_q, rem_d;

	// Write requests from the sequencer.
	logic        emit_req, push_req, add_req;
	logic [19:0] emit_idx;
	logic [63:0] emit_val, push_val;
	logic [31:0] add_k;

	// Scratch values of the sequencer step.
	logic [6:0]  room, fill, unused, r_v;
	logic [31:0] nm1, cb_v, cl, avail, nb;
	logic [63:0] m_c, m_v;
	logic        at_end, cond, touched, ty;

	// Result queue and per-item side information.
	ewah_pkg::entry_t q_mem [ewah_pkg::QDEPTH];
	logic [ewah_pkg::QPTR_BITS:0]   wptr_t_q, wptr_c_q, rptr_q, occ;
	logic                           mem_we, rd_en;
	logic [ewah_pkg::QPTR_BITS-1:0] mem_addr;
	ewah_pkg::entry_t               mem_wdata, rd_q;
	logic [47:0]                    sd_tot [ewah_pkg::QDEPTH];
	logic                           sd_ovf [ewah_pkg::QDEPTH];
	logic [ewah_pkg::QPTR_BITS-1:0] sd_end [ewah_pkg::QDEPTH];
	logic [ewah_pkg::QPTR_BITS-1:0] swp_q, srp_q;
	logic                           ov_q, last_q, oovf_q, rd_last;
	logic [47:0]                    otot_q;

	assign h_zero = h_op_q ? (h_n_q == 32'd0) : (h_b_q == 7'd0);
	assign occ    = wptr_c_q - rptr_q;
	assign space  = (occ <= 5'd8);
	assign item.ready = !hv_q || take;

	// Sequencer: one word write at most per step.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		bt_d = bt_q; wt_d = wt_q; mp_d = mp_q; mc_d = mc_q; tail_d = tail_q; ph_d = ph_q;
		n_d = n_q; sh_d = sh_q; cb_d = cb_q; rem_d = rem_q;
		emit_req = 1'b0; emit_idx = '0; emit_val = '0;
		push_req = 1'b0; push_val = '0;
		add_req = 1'b0; add_k = '0;
		fail_set = 1'b0; take = 1'b0; start = 1'b0;
		room = '0; fill = '0; unused = '0; r_v = '0;
		nm1 = '0; cb_v = '0; cl = 32'((mc_q & CLEAN_MASK) >> DIRTY_COUNT_BITS);
		avail = '0; nb = '0; m_c = mc_q; m_v = mc_q;
		at_end = (({1'b0, mp_q} + 21'd1) == wt_q);
		cond = 1'b0; touched = 1'b0; ty = tail_q[0];
		case (state_q)
			ewah_pkg::S_IDLE: begin
				if (hv_q) begin
					if (h_zero) begin
						take = 1'b1;
					end else if (space) begin
						take = 1'b1;
						start = 1'b1;
						state_d = h_op_q ? ewah_pkg::S_RUN_START : ewah_pkg::S_CHK_START;
					end
				end
			end
			ewah_pkg::S_RUN_START: begin
				if (wt_q == 21'd0) begin
					push_req = 1'b1;
					state_d = ewah_pkg::S_RUN_BODY;
				end else if (ph_q != 6'd0) begin
					// Fill the open literal first.
					room = 7'd64 - {1'b0, ph_q};
					fill = (n_q < {25'd0, room}) ? n_q[6:0] : room;
					tail_d = bit_q ? (tail_q | (ewah_pkg::low_mask(fill) << ph_q)) : tail_q;
					emit_req = 1'b1;
					emit_idx = 20'(wt_q - 21'd1);
					emit_val = tail_d;
					add_req = 1'b1;
					add_k = {25'd0, fill};
					n_d = n_q - {25'd0, fill};
					if (n_q == {25'd0, fill}) begin
						state_d = ewah_pkg::S_FINISH;
					end else begin
						ret_d = ewah_pkg::S_RUN_BODY;
						state_d = ewah_pkg::S_INTEG;
					end
				end else begin
					ret_d = ewah_pkg::S_RUN_BODY;
					state_d = ewah_pkg::S_INTEG;
				end
			end
			ewah_pkg::S_RUN_BODY: begin
				add_req = 1'b1;
				add_k = n_q;
				if (n_q <= 32'd64) begin
					push_req = 1'b1;
					push_val = bit_q ? ewah_pkg::low_mask(n_q[6:0]) : '0;
					state_d = ewah_pkg::S_FINISH;
				end else begin
					// Whole clean words, then a last literal of 1 to 64 bits.
					nm1 = n_q - 32'd1;
					cb_v = {6'd0, nm1[31:6]};
					rem_d = {1'b0, nm1[5:0]} + 7'd1;
					cond = (at_end && mc_q[63] == bit_q) || (mp_q == 20'd0 && mc_q == 64'd0);
					if (cond) begin
						avail = CMAX - cl;
						nb = (avail < cb_v) ? avail : cb_v;
						m_c = (mc_q & ~CLEAN_MASK) | ({32'd0, cl + nb} << DIRTY_COUNT_BITS);
						m_v = {bit_q, m_c[62:0]};
						cb_v = cb_v - nb;
						touched = 1'b1;
					end
					if (cb_v != 32'd0 && at_end) begin
						m_v = m_v & ~DMAX64;
						touched = 1'b1;
					end
					mc_d = m_v;
					cb_d = cb_v;
					if (touched) begin
						emit_req = 1'b1;
						emit_idx = mp_q;
						emit_val = m_v;
					end
					state_d = ewah_pkg::S_RUN_MARK;
				end
			end
			ewah_pkg::S_RUN_MARK: begin
				// New markers for the clean words left over, then the last literal.
				if (cb_q >= CMAX) begin
					push_req = 1'b1;
					push_val = {bit_q, CLEAN_MASK[62:0]};
					mc_d = push_val;
					mp_d = wt_q[19:0];
					cb_d = cb_q - CMAX;
				end else if (cb_q != 32'd0) begin
					m_c = {32'd0, cb_q} << DIRTY_COUNT_BITS;
					push_req = 1'b1;
					push_val = {bit_q, m_c[62:0]};
					mc_d = push_val;
					mp_d = wt_q[19:0];
					cb_d = '0;
				end else begin
					push_req = 1'b1;
					push_val = bit_q ? ewah_pkg::low_mask(rem_q) : '0;
					state_d = ewah_pkg::S_FINISH;
				end
			end
			ewah_pkg::S_CHK_START: begin
				if (wt_q == 21'd0) begin
					push_req = 1'b1;
					state_d = ewah_pkg::S_CHK_BODY;
				end else if (ph_q == 6'd0) begin
					ret_d = ewah_pkg::S_CHK_BODY;
					state_d = ewah_pkg::S_INTEG;
				end else begin
					state_d = ewah_pkg::S_CHK_BODY;
				end
			end
			ewah_pkg::S_CHK_BODY: begin
				unused = 7'd64 - {1'b0, ph_q};
				add_req = 1'b1;
				if (ph_q == 6'd0) begin
					push_req = 1'b1;
					push_val = v_q & ewah_pkg::low_mask(b_q);
					add_k = {25'd0, b_q};
					state_d = ewah_pkg::S_FINISH;
				end else if (b_q <= unused) begin
					tail_d = tail_q | ((v_q & ewah_pkg::low_mask(b_q)) << ph_q);
					emit_req = 1'b1;
					emit_idx = 20'(wt_q - 21'd1);
					emit_val = tail_d;
					add_k = {25'd0, b_q};
					state_d = ewah_pkg::S_FINISH;
				end else begin
					// Close the open literal; the rest goes to a new one.
					tail_d = tail_q | ((v_q & ewah_pkg::low_mask(unused)) << ph_q);
					emit_req = 1'b1;
					emit_idx = 20'(wt_q - 21'd1);
					emit_val = tail_d;
					add_k = {25'd0, unused};
					sh_d = unused;
					ret_d = ewah_pkg::S_CHK_REST;
					state_d = ewah_pkg::S_INTEG;
				end
			end
			ewah_pkg::S_CHK_REST: begin
				r_v = b_q - sh_q;
				push_req = 1'b1;
				push_val = (v_q >> sh_q[5:0]) & ewah_pkg::low_mask(r_v);
				add_req = 1'b1;
				add_k = {25'd0, r_v};
				state_d = ewah_pkg::S_FINISH;
			end
			ewah_pkg::S_INTEG: begin
				// Fold the full last literal into the marker structure.
				state_d = ret_q;
				emit_req = 1'b1;
				if (tail_q == 64'd0 || tail_q == '1) begin
					if ((wt_q == ({1'b0, mp_q} + 21'd2)) &&
							(cl == 32'd0 || (ty == mc_q[63] && cl != CMAX))) begin
						m_c = (mc_q & ~CLEAN_MASK) |
							({32'd0, cl + 32'd1} << DIRTY_COUNT_BITS);
						m_v = {ty, m_c[62:0]};
						mc_d = m_v;
						wt_d = wt_q - 21'd1;
						emit_idx = mp_q;
						emit_val = m_v;
					end else begin
						m_v = {ty, 63'd0} | (64'd1 << DIRTY_COUNT_BITS);
						mc_d = m_v;
						mp_d = 20'(wt_q - 21'd1);
						emit_idx = 20'(wt_q - 21'd1);
						emit_val = m_v;
					end
				end else if ((mc_q & DMAX64) == DMAX64) begin
					mc_d = 64'd1;
					mp_d = 20'(wt_q - 21'd1);
					emit_idx = 20'(wt_q - 21'd1);
					emit_val = 64'd1;
					state_d = ewah_pkg::S_INT_PUSH;
				end else begin
					mc_d = mc_q + 64'd1;
					emit_idx = mp_q;
					emit_val = mc_q + 64'd1;
				end
			end
			ewah_pkg::S_INT_PUSH: begin
				push_req = 1'b1;
				push_val = tail_q;
				state_d = ret_q;
			end
			ewah_pkg::S_FINISH: begin
				state_d = ewah_pkg::S_IDLE;
			end
			default: begin
				state_d = ewah_pkg::S_IDLE;
			end
		endcase

		if (add_req) begin
			bt_d = ewah_pkg::sat_add(bt_q, add_k);
			ph_d = ph_q + add_k[5:0];
		end
		if (push_req) begin
			if (wt_q >= MAXW) begin
				fail_set = 1'b1;
			end else begin
				wt_d = wt_q + 21'd1;
				tail_d = push_val;
				emit_req = 1'b1;
				emit_idx = wt_q[19:0];
				emit_val = push_val;
			end
		end
		if (emit_req && ecnt_q == ewah_pkg::MAX_RESULTS) begin
			fail_set = 1'b1;
		end
		if (fail_set) begin
			state_d = ewah_pkg::S_FINISH;
		end
	end

	// Queue write port: sequencer writes, or the single beat of a dropped item.
	always_comb begin
		mem_we = 1'b0;
		mem_addr = wptr_t_q[ewah_pkg::QPTR_BITS-1:0];
		mem_wdata = '{word_index: emit_idx, word_value: emit_val, word_count: wt_d};
		if (state_q == ewah_pkg::S_FINISH) begin
			mem_we = fail_q;
			mem_addr = wptr_c_q[ewah_pkg::QPTR_BITS-1:0];
			mem_wdata = '{word_index: (cwt_q != 21'd0) ? 20'(cwt_q - 21'd1) : 20'd0,
				word_value: (cwt_q != 21'd0) ? ctail_q : 64'd0,
				word_count: cwt_q};
		end else begin
			mem_we = emit_req && !fail_set;
		end
	end

	// Control and working state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ewah_pkg::S_IDLE;
			ret_q <= ewah_pkg::S_IDLE;
			hv_q <= 1'b0;
			bt_q <= '0; wt_q <= '0; mp_q <= '0; mc_q <= '0; tail_q <= '0; ph_q <= '0;
			cbt_q <= '0; cwt_q <= '0; cmp_q <= '0; cmc_q <= '0; ctail_q <= '0; cph_q <= '0;
			ovf_q <= 1'b0;
			fail_q <= 1'b0;
			ecnt_q <= '0;
			wptr_t_q <= '0;
			wptr_c_q <= '0;
			swp_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (item.valid && item.ready) begin
				hv_q <= 1'b1;
			end else if (take) begin
				hv_q <= 1'b0;
			end
			if (start) begin
				ecnt_q <= '0;
			end else if (mem_we && state_q != ewah_pkg::S_FINISH) begin
				ecnt_q <= ecnt_q + 4'd1;
			end
			if (mem_we && state_q != ewah_pkg::S_FINISH) begin
				wptr_t_q <= wptr_t_q + 5'd1;
			end
			if (state_q == ewah_pkg::S_FINISH) begin
				fail_q <= 1'b0;
				swp_q <= swp_q + 4'd1;
				if (fail_q) begin
					// Roll back to the state before the item.
					bt_q <= cbt_q; wt_q <= cwt_q; mp_q <= cmp_q;
					mc_q <= cmc_q; tail_q <= ctail_q; ph_q <= cph_q;
					ovf_q <= 1'b1;
					wptr_c_q <= wptr_c_q + 5'd1;
					wptr_t_q <= wptr_c_q + 5'd1;
				end else begin
					cbt_q <= bt_q; cwt_q <= wt_q; cmp_q <= mp_q;
					cmc_q <= mc_q; ctail_q <= tail_q; cph_q <= ph_q;
					wptr_c_q <= wptr_t_q;
				end
			end else begin
				fail_q <= fail_q || fail_set;
				bt_q <= bt_d; wt_q <= wt_d; mp_q <= mp_d;
				mc_q <= mc_d; tail_q <= tail_d; ph_q <= ph_d;
			end
		end
	end

	// Item payload registers.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			h_op_q <= item.operation;
			h_v_q <= item.chunk_value;
			h_b_q <= item.chunk_bits;
			h_bit_q <= item.run_bit;
			h_n_q <= item.run_length;
		end
		if (start) begin
			bit_q <= h_bit_q;
			n_q <= h_n_q;
			v_q <= h_v_q;
			b_q <= (h_b_q > 7'd64) ? 7'd64 : h_b_q;
		end else begin
			n_q <= n_d;
		end
		sh_q <= sh_d;
		cb_q <= cb_d;
		rem_q <= rem_d;
	end

	// Result queue memory and per-item side table.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			q_mem[mem_addr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= q_mem[rptr_q[ewah_pkg::QPTR_BITS-1:0]];
			otot_q <= sd_tot[srp_q];
			oovf_q <= sd_ovf[srp_q];
			last_q <= rd_last;
		end
		if (state_q == ewah_pkg::S_FINISH) begin
			sd_tot[swp_q] <= fail_q ? cbt_q : bt_q;
			sd_ovf[swp_q] <= fail_q | ovf_q;
			sd_end[swp_q] <= fail_q ? wptr_c_q[ewah_pkg::QPTR_BITS-1:0]
				: 4'(wptr_t_q - 5'd1);
		end
	end

	// Output stage: the registered queue read is the result register.
	assign rd_en = (rptr_q != wptr_c_q) && (!ov_q || result.ready);
	assign rd_last = (rptr_q[ewah_pkg::QPTR_BITS-1:0] == sd_end[srp_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			rptr_q <= '0;
			srp_q <= '0;
		end else begin
			if (rd_en) begin
				ov_q <= 1'b1;
				rptr_q <= rptr_q + 5'd1;
				if (rd_last) begin
					srp_q <= srp_q + 4'd1;
				end
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign result.valid      = ov_q;
	assign result.word_index = rd_q.word_index;
	assign result.word_value = rd_q.word_value;
	assign result.word_count = rd_q.word_count;
	assign result.total_bits = otot_q;
	assign result.overflow   = oovf_q;
	assign result.last_write = last_q;

endmodule

// ===== sv/ewah_checker.sv =====
// Port-level checks of the EWAH bitmap encoder and their bind to the top level.
// Depends on ewah_bitmap_encoder_unit and its channel interfaces.
module ewah_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [19:0] word_index,
	input logic [20:0] word_count,
	input logic [47:0] total_bits,
	input logic        overflow
);

	logic        seen_ovf_q, have_q;
	logic [47:0] last_tot_q;

	// Track what earlier delivered beats showed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_ovf_q <= 1'b0;
			have_q <= 1'b0;
			last_tot_q <= '0;
		end else if (res_valid && res_ready) begin
			seen_ovf_q <= seen_ovf_q | overflow;
			have_q <= 1'b1;
			last_tot_q <= total_bits;
		end
	end

	// A stalled beat holds its word index and bit total.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(word_index) && $stable(total_bits))
		else $error("result beat changed while stalled");

	// Overflow is sticky across beats.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seen_ovf_q |-> overflow)
		else $error("overflow flag dropped");

	// The written word lies inside the bitmap after the write.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, word_index} < word_count) ||
			(word_count == 21'd0 && word_index == 20'd0))
		else $error("word index beyond word count");

	// The bit total never decreases.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && have_q |-> total_bits >= last_tot_q)
		else $error("bit total decreased");

endmodule

bind ewah_bitmap_encoder_unit ewah_checker u_ewah_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.word_index(result.word_index),
	.word_count(result.word_count),
	.total_bits(result.total_bits),
	.overflow(result.overflow)
);
